// ===== rtl/wech_pkg.sv =====
// Shared constants and codes for the walk extreme contact histogram unit.
`timescale 1ns / 1ps
package wech_pkg;

  // Longest walk; tallies saturate here and the histogram has one bin more.
  localparam int WALK_LEN = 20;
  localparam int NBINS    = WALK_LEN + 1;

  // Field and storage widths.
  localparam int COORD_W = 7;
  localparam int TALLY_W = 6;
  localparam int IDX_W   = 5;
  localparam int BIN_W   = 64;
  localparam int HITS_W  = 3;
  localparam int INC_W   = 4;

  // Number of tracked extremes and their slots.
  localparam int NEXT = 4;
  localparam logic [1:0] EXT_XMAX = 2'd0;
  localparam logic [1:0] EXT_XMIN = 2'd1;
  localparam logic [1:0] EXT_YMAX = 2'd2;
  localparam logic [1:0] EXT_YMIN = 2'd3;

  // Request codes carried in req_type.
  localparam logic REQ_SITE = 1'b0;
  localparam logic REQ_READ = 1'b1;

endpackage

// ===== rtl/walk_extreme_contact_histogram_unit.sv =====
// Top level of the walk extreme contact histogram unit.
`timescale 1ns / 1ps
// The unit takes one transaction per clock cycle: either a walk site (signed x,y with a
// last-site flag) or a read of one histogram bin. A transaction is captured in an input
// register; a site is fully processed in the following cycle, where the four extremes,
// their contact tallies and, on the last site, the histogram bins are all updated
// together, so sites stream back to back with no bubbles. A read's bin goes from the input
// register through an output register to the output; the only thing that holds the
// input back is a read that finds that output register still occupied by an earlier
// result the consumer has not taken. Site transactions produce no result. The histogram
// is zero after reset.
module walk_extreme_contact_histogram_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic signed [wech_pkg::COORD_W-1:0] x_coord,
  input  logic signed [wech_pkg::COORD_W-1:0] y_coord,
  input  logic                                last_site,
  input  logic        [wech_pkg::IDX_W-1:0]   bin_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [wech_pkg::BIN_W-1:0]   bin_count
);
  import wech_pkg::*;

  // Input register.
  logic                      s1_valid;
  logic                      s1_req;
  logic signed [COORD_W-1:0] s1_x;
  logic signed [COORD_W-1:0] s1_y;
  logic                      s1_last;
  logic [IDX_W-1:0]          s1_idx;

  // Walk state and histogram.
  logic                      in_walk;
  logic signed [COORD_W-1:0] ext_coord [NEXT];
  logic [TALLY_W-1:0]        ext_tally [NEXT];
  logic [BIN_W-1:0]          hist [NBINS];

  // Next values from the processing stage.
  logic signed [COORD_W-1:0] ext_coord_next [NEXT];
  logic [TALLY_W-1:0]        ext_tally_next [NEXT];
  logic [INC_W-1:0]          bin_add [NBINS];
  logic                      flat;
  logic                      s1_go;
  logic                      site_go;
  logic                      read_go;
  logic [BIN_W-1:0]          rd_data;

  // A site always completes; a read completes when the output register is empty or its result is being taken.
  assign read_go  = s1_valid && (s1_req == REQ_READ) && (!out_valid || out_ready);
  assign site_go  = s1_valid && (s1_req == REQ_SITE);
  assign s1_go    = read_go || site_go;
  assign in_ready = !s1_valid || s1_go;

  // Capture an accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_req  <= req_type;
      s1_x    <= x_coord;
      s1_y    <= y_coord;
      s1_last <= last_site;
      s1_idx  <= bin_index;
    end
  end

  // Extreme tracking: each slot compares the site against its stored extreme.
  always_comb begin
    for (int k = 0; k < NEXT; k++) begin
      logic signed [COORD_W-1:0] v;
      logic                      beyond;
      v = ((k == int'(EXT_XMAX)) || (k == int'(EXT_XMIN))) ? s1_x : s1_y;
      beyond = ((k == int'(EXT_XMAX)) || (k == int'(EXT_YMAX))) ?
               (v > ext_coord[k]) : (v < ext_coord[k]);
      ext_coord_next[k] = ext_coord[k];
      ext_tally_next[k] = ext_tally[k];
      if (!in_walk) begin
        ext_coord_next[k] = v;
        ext_tally_next[k] = TALLY_W'(1);
      end else if (beyond) begin
        ext_coord_next[k] = v;
        ext_tally_next[k] = TALLY_W'(1);
      end else if ((v == ext_coord[k]) && (ext_tally[k] < TALLY_W'(WALK_LEN))) begin
        ext_tally_next[k] = ext_tally[k] + TALLY_W'(1);
      end
    end
  end

  // A walk with no extent in x or in y adds 1 per contact, otherwise 2.
  assign flat = (ext_coord_next[EXT_XMAX] == ext_coord_next[EXT_XMIN]) ||
                (ext_coord_next[EXT_YMAX] == ext_coord_next[EXT_YMIN]);

  // Per-bin increment: the number of extremes whose tally lands on the bin, scaled.
  always_comb begin
    for (int b = 0; b < NBINS; b++) begin
      logic [HITS_W-1:0] hits;
      hits = '0;
      for (int k = 0; k < NEXT; k++) begin
        if (ext_tally_next[k] == TALLY_W'(b)) begin
          hits = hits + HITS_W'(1);
        end
      end
      bin_add[b] = flat ? INC_W'(hits) : INC_W'({hits, 1'b0});
    end
  end

  // Walk state updates on each site; the histogram updates on the last site of a walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_walk <= 1'b0;
      for (int k = 0; k < NEXT; k++) begin
        ext_coord[k] <= '0;
        ext_tally[k] <= '0;
      end
      for (int b = 0; b < NBINS; b++) begin
        hist[b] <= '0;
      end
    end else if (site_go) begin
      in_walk <= !s1_last;
      for (int k = 0; k < NEXT; k++) begin
        ext_coord[k] <= ext_coord_next[k];
        ext_tally[k] <= ext_tally_next[k];
      end
      if (s1_last) begin
        for (int b = 0; b < NBINS; b++) begin
          hist[b] <= hist[b] + BIN_W'(bin_add[b]);
        end
      end
    end
  end

  // Bin read; an index past the last bin reads as zero.
  assign rd_data = (s1_idx < IDX_W'(NBINS)) ? hist[s1_idx] : '0;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (read_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (read_go) begin
      bin_count <= rd_data;
    end
  end

endmodule

// ===== rtl/wech_checker.sv =====
// Port-level checker for the walk extreme contact histogram unit, with its bind.
`timescale 1ns / 1ps
module wech_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        req_type,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wech_pkg::BIN_W-1:0]  bin_count
);
  import wech_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bin_count))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // The input only stalls behind an untaken result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

  // A new result comes from a read transaction accepted through the input register.
  a_rise_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && !$past(rst, 1) && !$past(rst, 2) |->
      $past(in_valid && in_ready && (req_type == REQ_READ), 2))
    else $error("result without a matching read transaction");

endmodule

bind walk_extreme_contact_histogram_unit wech_checker u_wech_checker (.*);

// ===== dv/tb_walk_extreme_contact_histogram_unit.sv =====
// Testbench for the walk extreme contact histogram unit: walks, random walks, bin reads.
`timescale 1ns / 1ps
module tb_walk_extreme_contact_histogram_unit;
  import wech_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int RESET_CYCLES = 7;
  localparam int ITEM_TARGET = 1950;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT = 2000;
  localparam int MAX_GAP     = 12;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      req_type;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic                      last_site;
  logic [IDX_W-1:0]          bin_index;
  logic                      out_valid;
  logic                      out_ready;
  logic [BIN_W-1:0]          bin_count;

  // Shadow copy of the walk trackers and the histogram.
  logic                      walk_open;
  logic signed [COORD_W-1:0] walk_ext [NEXT];
  logic [TALLY_W-1:0]        walk_tally [NEXT];
  logic [BIN_W-1:0]          contact_hist [NBINS];
  logic [BIN_W-1:0]          expected_bins [$];

  int  errors;
  int  items_sent;
  int  sites_sent;
  int  walks_closed;
  int  reads_sent;
  int  bins_checked;
  int  holds_done;
  bit  no_idle;
  bit  hold_output;

  walk_extreme_contact_histogram_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .last_site (last_site),
    .bin_index (bin_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bin_count (bin_count)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [BIN_W-1:0] exp_val,
                                 input logic [BIN_W-1:0] got_val);
    $display("ERROR: %0t %s: expected %0d, got %0d", $realtime, what, exp_val, got_val);
    errors++;
  endtask

  // Move one extreme: a strictly better value restarts the tally, a tie adds to it.
  task automatic track_extreme(input int slot, input logic signed [COORD_W-1:0] v,
                               input bit is_max);
    if ((is_max && v > walk_ext[slot]) || (!is_max && v < walk_ext[slot])) begin
      walk_ext[slot]   = v;
      walk_tally[slot] = 1;
    end else if (v == walk_ext[slot] && walk_tally[slot] < WALK_LEN) begin
      walk_tally[slot] = walk_tally[slot] + 1'b1;
    end
  endtask

  // Apply one accepted transaction to the shadow state; a read queues its bin value.
  task automatic update_contact_model(input logic req, input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y, input logic last,
                                      input logic [IDX_W-1:0] idx);
    logic [BIN_W-1:0] step;
    bit               flat;
    items_sent++;
    if (req == REQ_READ) begin
      expected_bins.push_back((idx < NBINS) ? contact_hist[idx] : '0);
      reads_sent++;
    end else begin
      sites_sent++;
      if (!walk_open) begin
        walk_ext[EXT_XMAX] = x;
        walk_ext[EXT_XMIN] = x;
        walk_ext[EXT_YMAX] = y;
        walk_ext[EXT_YMIN] = y;
        for (int k = 0; k < NEXT; k++) walk_tally[k] = 1;
      end else begin
        track_extreme(int'(EXT_XMAX), x, 1'b1);
        track_extreme(int'(EXT_XMIN), x, 1'b0);
        track_extreme(int'(EXT_YMAX), y, 1'b1);
        track_extreme(int'(EXT_YMIN), y, 1'b0);
      end
      if (last) begin
        flat = (walk_ext[EXT_XMAX] == walk_ext[EXT_XMIN]) ||
               (walk_ext[EXT_YMAX] == walk_ext[EXT_YMIN]);
        step = flat ? 64'd1 : 64'd2;
        for (int k = 0; k < NEXT; k++) begin
          if (walk_tally[k] < NBINS) contact_hist[walk_tally[k]] += step;
        end
        walk_open = 1'b0;
        walks_closed++;
      end else begin
        walk_open = 1'b1;
      end
    end
  endtask

  // Offer one transaction after a random gap and hold it until the unit takes it.
  task automatic send_transaction(input logic req, input logic signed [COORD_W-1:0] x,
                                  input logic signed [COORD_W-1:0] y, input logic last,
                                  input logic [IDX_W-1:0] idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type  = req;
    x_coord   = x;
    y_coord   = y;
    last_site = last;
    bin_index = idx;
    in_valid  = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    update_contact_model(req, x, y, last, idx);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord(input int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v[COORD_W-1:0];
  endfunction

  // A site carries a random bin_index, a read carries random coordinates and flag.
  task automatic send_site(input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y, input logic last);
    send_transaction(REQ_SITE, x, y, last, IDX_W'($urandom));
  endtask

  task automatic send_read(input logic [IDX_W-1:0] idx);
    send_transaction(REQ_READ, COORD_W'($urandom), COORD_W'($urandom),
                     1'($urandom), idx);
  endtask

  // A complete walk of random sites, with reads sprinkled in between.
  task automatic run_walk(input int len, input int span, input int read_pct);
    for (int i = 0; i < len; i++) begin
      send_site(rand_coord(span), rand_coord(span), i == len - 1);
      if (int'($urandom_range(0, 99)) < read_pct) send_read(IDX_W'($urandom));
    end
  endtask

  task automatic test_reset_reads();
    send_read(0);
    send_read(IDX_W'(WALK_LEN));
    send_read(5'd31);
  endtask

  task automatic test_single_site_walk();
    send_site(0, 0, 1'b1);
    send_read(1);
  endtask

  // Four corners at +/-32, with a read while the walk is open.
  task automatic test_corner_walk();
    send_site(-32, -32, 1'b0);
    send_site(32, 32, 1'b0);
    send_read(2);
    send_site(32, -32, 1'b0);
    send_site(-32, 32, 1'b1);
    send_read(2);
  endtask

  // Walks with zero extent in x and then in y, plus reads past the last bin.
  task automatic test_flat_walks();
    send_site(5, 0, 1'b0);
    send_site(5, 32, 1'b0);
    send_site(5, -32, 1'b0);
    send_site(5, -32, 1'b1);
    send_site(-1, 7, 1'b0);
    send_site(3, 7, 1'b1);
    send_read(4);
    send_read(1);
    send_read(IDX_W'(NBINS));
    send_read(5'd31);
  endtask

  // Long walks on one value or on values in -1..1 drive the tallies into saturation.
  task automatic test_tally_saturation();
    run_walk(25, 0, 0);
    run_walk(32, 1, 5);
    run_walk(WALK_LEN, 0, 0);
    send_read(IDX_W'(WALK_LEN));
    send_read(IDX_W'(WALK_LEN - 1));
  endtask

  // The receiver stops for a long stretch while reads keep coming.
  task automatic test_output_backpressure();
    hold_output = 1'b1;
    no_idle     = 1'b1;
    for (int i = 0; i < 16; i++) send_read(IDX_W'(i));
    no_idle = 1'b0;
  endtask

  task automatic test_random_walks();
    int pick;
    int len;
    int span;
    while (items_sent < ITEM_TARGET) begin
      no_idle = (items_sent >= 700 && items_sent < 1000);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
        case ($urandom_range(0, 4))
          0: span = 0;
          1: span = 1;
          2: span = 2;
          3: span = 6;
          default: span = 32;
        endcase
        run_walk(len, span, 12);
      end else if (pick < 90) begin
        send_read(IDX_W'($urandom));
      end else begin
        send_site(rand_coord(32), rand_coord(32), 1'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  // Consumer side: random stalls per result, or one long hold when asked.
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_output) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
        holds_done++;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (stall > 0) begin
          out_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready = 1'b1;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
      @(negedge clk);
    end
  end

  // Compare each returned bin with the oldest outstanding read.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_bins.size() == 0) begin
        report_mismatch("bin_count with no read outstanding", '0, bin_count);
      end else begin
        logic [BIN_W-1:0] exp_val;
        exp_val = expected_bins.pop_front();
        if (bin_count !== exp_val) report_mismatch("bin_count", exp_val, bin_count);
      end
      bins_checked++;
    end
  end

  initial begin
    int waited;
    errors       = 0;
    items_sent   = 0;
    sites_sent   = 0;
    walks_closed = 0;
    reads_sent   = 0;
    bins_checked = 0;
    holds_done   = 0;
    no_idle      = 1'b0;
    hold_output  = 1'b0;
    walk_open    = 1'b0;
    for (int k = 0; k < NEXT; k++) begin
      walk_ext[k]   = '0;
      walk_tally[k] = '0;
    end
    for (int k = 0; k < NBINS; k++) contact_hist[k] = '0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    req_type  = REQ_SITE;
    x_coord   = '0;
    y_coord   = '0;
    last_site = 1'b0;
    bin_index = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    test_reset_reads();
    test_single_site_walk();
    test_corner_walk();
    test_flat_walks();
    test_tally_saturation();
    test_output_backpressure();
    test_random_walks();

    // Let every outstanding read come back, then stay idle before the report.
    @(negedge clk);
    in_valid = 1'b0;
    waited = 0;
    while (expected_bins.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_bins.size() != 0) begin
      report_mismatch("reads never answered", BIN_W'(expected_bins.size()), '0);
    end
    repeat (10) @(posedge clk);

    $display("Run covered %0d sites in %0d closed walks and %0d bin reads.",
             sites_sent, walks_closed, reads_sent);
    $display("Checked %0d returned bins; long output holds: %0d; mismatches: %0d.",
             bins_checked, holds_done, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
